@@ rtl/lkv_pkg.sv @@
package lkv_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 16;
    localparam int unsigned KEY_W           = 32;
    localparam int unsigned VAL_W           = 32;
    localparam int unsigned CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] store_value;
    } lkv_req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } lkv_resp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkv_entry_t;

    typedef struct packed {
        logic go;
        logic put_miss;
        logic evict;
    } lkv_cell_ctrl_t;

endpackage

@@ rtl/lkv_cell.sv @@
module lkv_cell
    import lkv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  lkv_cell_ctrl_t   ctrl,
    input  logic [KEY_W-1:0] op_key,
    input  lkv_entry_t       left_entry,
    output lkv_entry_t       entry,
    input  logic             seen_in,
    output logic             seen_out,
    input  logic [VAL_W-1:0] hit_val_in,
    output logic [VAL_W-1:0] hit_val_out
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             match;
    logic             shift;

    assign match       = valid_reg && (key_reg == op_key);
    // a match here or further towards the old end moves this cell along
    assign seen_out    = match || seen_in;
    assign hit_val_out = (match ? value_reg : '0) | hit_val_in;
    assign shift       = seen_out || ctrl.put_miss;

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.go) begin
            // eviction acts on the post-shift position, so it wins
            if (ctrl.evict) begin
                valid_reg <= 1'b0;
            end else if (shift) begin
                valid_reg <= left_entry.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.go && shift) begin
            key_reg   <= left_entry.key;
            value_reg <= left_entry.value;
        end
    end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-used replacement, built as a row of
// ENTRIES cells kept in recency order: the cell at the head holds the most recent entry and
// valid entries always sit in a contiguous run from the head. A get or put is registered on
// transfer, then, once it proceeds, every cell compares its key, the hit/miss and hit value
// ripple down the row, and the cells ahead of the hit (or all cells on an insert) shift one
// place towards the tail while the head takes the touched entry; an over-capacity put clears
// the last valid cell. A get result is loaded into the result register as the get proceeds.
// One item is taken every cycle; a get waits only while the result register is still full
// and not being read. The key-compare and shift chain along the row sets the clock period.
// Valid bits clear at reset, so there is no clearing pass. Capacity writes are always taken.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lkv_req_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lkv_resp_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             op_valid_reg;
    lkv_req_t         op_reg;
    logic             m_valid_reg;
    lkv_resp_t        m_data_reg;

    logic             op_get;
    logic             go;
    logic             hit;
    logic             put_miss;
    logic [OCC_W-1:0] occ_after;
    logic [OCC_W-1:0] evict_slot;
    logic [IDX_W-1:0] evict_pos;
    logic [CMP_W-1:0] cap_eff;
    logic             do_evict;
    lkv_entry_t       head_entry;

    lkv_entry_t       cell_entry [ENTRIES];
    logic [ENTRIES:0] seen;
    logic [VAL_W-1:0] hit_val [ENTRIES+1];

    assign cfg_ready = 1'b1;

    assign op_get  = (op_reg.func == FUNC_GET);
    assign go      = op_valid_reg && (!op_get || !m_valid_reg || m_ready);
    assign s_ready = !op_valid_reg || go;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign seen[ENTRIES]    = 1'b0;
    assign hit_val[ENTRIES] = '0;
    assign hit              = seen[0];
    assign put_miss         = !op_get && !hit;

    assign head_entry.valid = 1'b1;
    assign head_entry.key   = op_reg.lookup_key;
    assign head_entry.value = op_get ? hit_val[0] : op_reg.store_value;

    // a full row drops its tail on insert, so the count holds there
    assign occ_after  = (put_miss && (occ_reg != OCC_W'(ENTRIES))) ? occ_reg + OCC_W'(1)
                                                                 : occ_reg;
    assign cap_eff    = (CMP_W'(capacity_reg) < CMP_W'(ENTRIES)) ? CMP_W'(capacity_reg)
                                                                 : CMP_W'(ENTRIES);
    assign do_evict   = !op_get && (CMP_W'(occ_after) > cap_eff);
    assign evict_slot = occ_after - OCC_W'(1);
    assign evict_pos  = evict_slot[IDX_W-1:0];
    assign occ_next   = do_evict ? evict_slot : occ_after;

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++) begin : g_cell
            lkv_cell_ctrl_t ctrl;
            lkv_entry_t     left_entry;

            assign ctrl.go       = go;
            assign ctrl.put_miss = put_miss;
            assign ctrl.evict    = do_evict && (evict_pos == IDX_W'(i));

            if (i == 0) begin : g_head
                assign left_entry = head_entry;
            end else begin : g_body
                assign left_entry = cell_entry[i-1];
            end

            lkv_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .op_key      (op_reg.lookup_key),
                .left_entry  (left_entry),
                .entry       (cell_entry[i]),
                .seen_in     (seen[i+1]),
                .seen_out    (seen[i]),
                .hit_val_in  (hit_val[i+1]),
                .hit_val_out (hit_val[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            occ_reg      <= '0;
            op_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (go) begin
                occ_reg <= occ_next;
            end
            if (s_valid && s_ready) begin
                op_valid_reg <= 1'b1;
            end else if (go) begin
                op_valid_reg <= 1'b0;
            end
            if (go && op_get) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_data;
        end
        if (go && op_get) begin
            m_data_reg.hit        <= hit;
            m_data_reg.read_value <= hit_val[0];
        end
    end

endmodule

@@ rtl/lkv_checker.sv @@
module lkv_checker
    import lkv_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input lkv_req_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input lkv_resp_t m_data
);

    // input side only backs up behind an unread result
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // a fresh result comes from a get transfer that passed through the op and result registers
    a_result_from_get: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_data.func == FUNC_GET), 2))
        else $error("result without a matching get");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.read_value == '0))
        else $error("miss with non-zero value");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ bench/lkv_cache_checker.sv @@
module lkv_cache_checker
    import lkv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  lkv_req_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  lkv_resp_t        m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               outstanding,
    output int               failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = ENTRIES_DEFAULT;

    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [VAL_W-1:0] slot_value [SLOTS];
    logic             slot_live  [SLOTS];
    int               slot_rank  [SLOTS];
    int               live_count;
    logic [CAP_W-1:0] capacity;
    lkv_resp_t        pending_lookups [$];
    int               mismatch_count = 0;

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_live[i]) return i;
        return -1;
    endfunction

    // rank 0 is the most recent entry
    function automatic void make_most_recent(input int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void evict_least_recent();
        int victim;
        victim = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        if (victim >= 0) begin
            slot_live[victim] = 1'b0;
            slot_rank[victim] = 0;
            live_count--;
        end
    endfunction

    function automatic lkv_resp_t cache_get(input logic [KEY_W-1:0] key);
        lkv_resp_t resp;
        int        s;
        s = find_slot(key);
        resp.hit        = (s >= 0);
        resp.read_value = '0;
        if (s >= 0) begin
            make_most_recent(s);
            resp.read_value = slot_value[s];
        end
        return resp;
    endfunction

    function automatic void cache_put(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
        int s;
        int limit;
        limit = (capacity < SLOTS) ? int'(capacity) : SLOTS;
        s = find_slot(key);
        if (s >= 0) begin
            slot_value[s] = value;
            make_most_recent(s);
        end else begin
            s = first_free_slot();
            // a full store frees its oldest slot before the insert
            if (s < 0) begin
                evict_least_recent();
                s = first_free_slot();
            end
            if (s >= 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i]) slot_rank[i]++;
                slot_key[s]   = key;
                slot_value[s] = value;
                slot_live[s]  = 1'b1;
                slot_rank[s]  = 0;
                live_count++;
            end
        end
        if (live_count > limit) evict_least_recent();
    endfunction

    always @(posedge aclk) begin
        lkv_resp_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_live[i] = 1'b0;
                slot_rank[i] = 0;
            end
            live_count = 0;
            capacity   = CAPACITY_RESET;
            pending_lookups.delete();
        end else begin
            // results come from earlier transfers, so check before taking a new request
            if (m_valid && m_ready) begin
                if (pending_lookups.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result hit=%0b value=%h",
                                 $time, m_data.hit, m_data.read_value);
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_data.hit !== want.hit || m_data.read_value !== want.read_value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch expected hit=%0b value=%h, got hit=%0b value=%h",
                                     $time, want.hit, want.read_value,
                                     m_data.hit, m_data.read_value);
                    end
                end
            end
            if (cfg_valid && cfg_ready) capacity = cfg_data;
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_GET)
                    pending_lookups.push_back(cache_get(s_data.lookup_key));
                else
                    cache_put(s_data.lookup_key, s_data.store_value);
            end
        end
        outstanding <= pending_lookups.size();
        failures    <= mismatch_count;
    end

endmodule

@@ bench/tb_lru_key_value_cache.sv @@
module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import lkv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLDOFF_CYCLES = 64;
    localparam int POOL_MAX       = 24;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    lkv_req_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    lkv_resp_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    int outstanding;
    int failures;
    int send_idle      = 0;
    int recv_idle      = 0;
    int holdoffs_asked = 0;
    int holdoffs_done  = 0;
    int holdoff_left   = 0;
    int quiet_cycles   = 0;

    logic [KEY_W-1:0] key_pool [POOL_MAX];
    logic [KEY_W-1:0] last_put_key = '0;

    always #5ns aclk = ~aclk;

    lru_key_value_cache DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lkv_cache_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    // result side: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge aclk) begin
        if (holdoffs_done != holdoffs_asked) begin
            holdoffs_done = holdoffs_asked;
            holdoff_left  = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_key_value_cache test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_data  <= '{func: func, lookup_key: key, store_value: value};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == FUNC_PUT) last_put_key = key;
    endtask

    // called at the edge of the last transfer: drop valid, drain results, then let puts finish
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle(4);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] phase_cap [8];
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             func;
        int               pool_size;
        int               pick;

        phase_cap = '{5'd16, 5'd31, 5'd4, 5'd0, 5'd15, 5'd1, 5'd17, 5'd16};
        send_idle = 21;
        recv_idle = 54;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_capacity(5'd16);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // capacity dropped under occupancy: puts of known keys drain one entry each
        write_capacity(5'd0);
        send_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0001);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0002);
        // empty store at capacity zero keeps nothing
        send_item(FUNC_PUT, 32'h0000_0007, 32'h0000_0003);
        send_item(FUNC_GET, 32'h0000_0007, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);

        write_capacity(5'd2);
        send_item(FUNC_PUT, 32'h0000_0010, 32'hA5A5_A5A5);
        send_item(FUNC_PUT, 32'h0000_0011, 32'h5A5A_5A5A);
        send_item(FUNC_GET, 32'h0000_0010, 32'h0000_0000);
        send_item(FUNC_PUT, 32'h0000_0012, 32'hC3C3_C3C3);
        send_item(FUNC_GET, 32'h0000_0011, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0012, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0010, 32'h0000_0000);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 3) begin
                send_idle = 54;
                recv_idle = 21;
            end else if (phase == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (phase == 7) phase_cap[phase] = CAP_W'($urandom_range(31));
            write_capacity(phase_cap[phase]);

            // small key set sized to the capacity so that gets mostly hit
            pool_size = ((phase_cap[phase] < 16) ? int'(phase_cap[phase]) : 16) + 4;
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < POOL_MAX; i++) key_pool[i] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 100) holdoffs_asked++;
                if (phase == 5 && n == 100) settle(0);
                pick = $urandom_range(99);
                func = $urandom_range(1) ? FUNC_PUT : FUNC_GET;
                if (pick < 10)
                    key = $urandom;
                else if (pick < 25 && func == FUNC_GET)
                    key = last_put_key;
                else
                    key = key_pool[$urandom_range(pool_size - 1)];
                value = $urandom;
                if (pick >= 95) value = (pick[0]) ? '1 : '0;
                send_item(func, key, value);
            end
        end

        settle(8);
        if (failures == 0 && outstanding == 0) begin
            $display("lru_key_value_cache test passed");
        end else begin
            $display("lru_key_value_cache test failed");
        end
        $finish;
    end

endmodule
